// ===== src/ialu_pkg.sv =====
// package: opcodes and shared types for the integer alu
package ialu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned CountWidth = 5;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_POW = 3'd4,
    OP_REM = 3'd5,
    OP_SQR = 3'd6,
    OP_NOP = 3'd7
  } opcode_t;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_LOAD  = 3'd1,
    CMD_DSTEP = 3'd2,
    CMD_PMUL  = 3'd3,
    CMD_PSQR  = 3'd4,
    CMD_FIN   = 3'd5
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
  } ctrl_t;

  typedef struct packed {
    logic                  multi;
    logic                  is_div;
    logic                  exp_zero;
    logic                  exp_odd;
    logic [CountWidth-1:0] count;
  } stat_t;

endpackage

// ===== src/integer_alu_with_div_pow.sv =====
// 32-bit integer alu: add, sub, mul, divide, remainder, power, square
// add/sub/mul: the result is computed at load, then registered to the output; div/rem: one quotient bit per divide step
// power: a squaring per exponent bit up to the top set bit, plus a multiply per set bit
// one request at a time; the next is taken once the output register is empty or draining,
// and only after the previous result has been handed to the output register
// synchronous active-high reset clears control state only
module integer_alu_with_div_pow
  import ialu_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic signed [DataWidth-1:0] operand_a,
  input  logic signed [DataWidth-1:0] operand_b,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [DataWidth-1:0] result,
  output logic                        divide_by_zero
);

  ctrl_t                ctrl;
  stat_t                stat;
  logic [DataWidth-1:0] res_u;

  ialu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  ialu_datapath u_dp (
    .clk           (clk),
    .ctrl          (ctrl),
    .opcode        (opcode),
    .operand_a     (operand_a),
    .operand_b     (operand_b),
    .stat          (stat),
    .result        (res_u),
    .divide_by_zero(divide_by_zero)
  );

  assign result = res_u;

endmodule

// ===== src/ialu_datapath.sv =====
// datapath: operand registers, restoring divider, square-and-multiply power
module ialu_datapath
  import ialu_pkg::*;
(
  input  logic                 clk,
  input  ctrl_t                ctrl,
  input  logic [2:0]           opcode,
  input  logic [DataWidth-1:0] operand_a,
  input  logic [DataWidth-1:0] operand_b,
  output stat_t                stat,
  output logic [DataWidth-1:0] result,
  output logic                 divide_by_zero
);

  logic [DataWidth-1:0]  acc;
  logic [DataWidth-1:0]  sq;
  logic [DataWidth-1:0]  ex;
  logic [DataWidth-1:0]  rem;
  logic [CountWidth-1:0] count;
  opcode_t               op;
  logic                  neg_q;
  logic                  neg_r;
  logic                  dz;

  logic [DataWidth-1:0] mag_a;
  logic [DataWidth-1:0] mag_b;
  logic [DataWidth:0]   trial;
  logic [DataWidth-1:0] rem_shift;
  logic [DataWidth-1:0] fast;
  logic [DataWidth-1:0] div_res;

  assign mag_a = operand_a[DataWidth-1] ? (~operand_a + 1'b1) : operand_a;
  assign mag_b = operand_b[DataWidth-1] ? (~operand_b + 1'b1) : operand_b;
  assign rem_shift = {rem[DataWidth-2:0], acc[DataWidth-1]};
  assign trial = {1'b0, rem_shift} - {1'b0, sq};

  always_comb begin
    case (opcode_t'(opcode))
      OP_ADD:  fast = operand_a + operand_b;
      OP_SUB:  fast = operand_a - operand_b;
      OP_MUL:  fast = operand_a * operand_b;
      default: fast = '0;
    endcase
  end

  always_comb begin
    if (dz) begin
      div_res = '0;
    end else if (op == OP_DIV) begin
      div_res = neg_q ? (~acc + 1'b1) : acc;
    end else begin
      div_res = neg_r ? (~rem + 1'b1) : rem;
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_LOAD: begin
        op    <= opcode_t'(opcode);
        count <= '1;
        rem   <= '0;
        dz    <= (operand_b == '0) &&
                 (opcode_t'(opcode) == OP_DIV || opcode_t'(opcode) == OP_REM);
        neg_q <= operand_a[DataWidth-1] ^ operand_b[DataWidth-1];
        neg_r <= operand_a[DataWidth-1];
        if (opcode_t'(opcode) == OP_DIV || opcode_t'(opcode) == OP_REM) begin
          acc <= mag_a;
          sq  <= mag_b;
        end else if (opcode_t'(opcode) == OP_POW || opcode_t'(opcode) == OP_SQR) begin
          acc <= DataWidth'(1);
          sq  <= operand_a;
        end else begin
          acc <= fast;
          sq  <= operand_a;
        end
        if (opcode_t'(opcode) == OP_SQR) begin
          ex <= DataWidth'(2);
        end else if (operand_b[DataWidth-1]) begin
          ex <= '0;
        end else begin
          ex <= operand_b;
        end
      end
      CMD_DSTEP: begin
        count <= count - 1'b1;
        if (!trial[DataWidth]) begin
          rem <= trial[DataWidth-1:0];
          acc <= {acc[DataWidth-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          acc <= {acc[DataWidth-2:0], 1'b0};
        end
      end
      CMD_PMUL: begin
        acc <= acc * sq;
      end
      CMD_PSQR: begin
        sq <= sq * sq;
        ex <= {1'b0, ex[DataWidth-1:1]};
      end
      CMD_FIN: begin
        result         <= (op == OP_DIV || op == OP_REM) ? div_res : acc;
        divide_by_zero <= dz;
      end
      default: begin
      end
    endcase
  end

  assign stat.multi    = (op == OP_DIV || op == OP_REM || op == OP_POW || op == OP_SQR);
  assign stat.is_div   = (op == OP_DIV || op == OP_REM);
  assign stat.exp_zero = (ex == '0);
  assign stat.exp_odd  = ex[0];
  assign stat.count    = count;

endmodule

// ===== src/ialu_ctrl.sv =====
// controller: sequences load, divide steps, power steps and result hand-off
module ialu_ctrl
  import ialu_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctrl_t ctrl
);

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_DIV, S_PMUL, S_PSQR, S_FIN} state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    case (state)
      S_IDLE:  ctrl.cmd = (in_valid && in_ready) ? CMD_LOAD : CMD_IDLE;
      S_DIV:   ctrl.cmd = CMD_DSTEP;
      S_PMUL:  ctrl.cmd = CMD_PMUL;
      S_PSQR:  ctrl.cmd = CMD_PSQR;
      S_FIN:   ctrl.cmd = (!out_valid || out_ready) ? CMD_FIN : CMD_IDLE;
      default: ctrl.cmd = CMD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!stat.multi) begin
            state <= S_FIN;
          end else if (stat.is_div) begin
            state <= S_DIV;
          end else if (stat.exp_zero) begin
            state <= S_FIN;
          end else if (stat.exp_odd) begin
            state <= S_PMUL;
          end else begin
            state <= S_PSQR;
          end
        end
        S_DIV: begin
          if (stat.count == '0) begin
            state <= S_FIN;
          end
        end
        S_PMUL: begin
          state <= S_PSQR;
        end
        S_PSQR: begin
          state <= S_DECIDE;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("request accepted while busy");
  a_load_once: assert property (@(posedge clk) disable iff (rst)
    (ctrl.cmd == CMD_LOAD) |=> (state == S_DECIDE)) else $error("load not followed by decode");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && stat.count == '0) |=> (state == S_FIN)) else $error("divider overrun");

endmodule

// ===== test/tb_integer_alu_with_div_pow_checker.sv =====
// checker: watches both channels, predicts alu results and compares them
module tb_integer_alu_with_div_pow_checker
  import ialu_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  logic [2:0]                  opcode,
  input  logic signed [DataWidth-1:0] operand_a,
  input  logic signed [DataWidth-1:0] operand_b,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  logic signed [DataWidth-1:0] result,
  input  logic                        divide_by_zero,
  output int                          errors,
  output int                          pending
);

  typedef struct packed {
    logic [31:0] value;
    logic        dz;
  } alu_answer_t;

  alu_answer_t answers_q[$];

  function automatic logic [31:0] power_wrap(logic [31:0] base, logic [31:0] ex);
    logic [31:0] acc;
    logic [31:0] sq;
    logic [31:0] e;
    acc = 32'd1;
    sq = base;
    e = ex;
    if (e[31]) begin
      return 32'd1;
    end
    while (e != 0) begin
      if (e[0]) begin
        acc = acc * sq;
      end
      sq = sq * sq;
      e = e >> 1;
    end
    return acc;
  endfunction

  function automatic alu_answer_t compute_answer(logic [2:0] op, logic [31:0] a,
                                                 logic [31:0] b);
    alu_answer_t ans;
    logic [31:0] ma;
    logic [31:0] mb;
    ans = '0;
    ma = a[31] ? -a : a;
    mb = b[31] ? -b : b;
    case (opcode_t'(op))
      OP_ADD: ans.value = a + b;
      OP_SUB: ans.value = a - b;
      OP_MUL: ans.value = a * b;
      OP_DIV, OP_REM: begin
        if (b == 0) begin
          ans.dz = 1'b1;
        end else if (opcode_t'(op) == OP_DIV) begin
          ans.value = (a[31] != b[31]) ? -(ma / mb) : ma / mb;
        end else begin
          ans.value = a[31] ? -(ma % mb) : ma % mb;
        end
      end
      OP_POW: ans.value = power_wrap(a, b);
      OP_SQR: ans.value = power_wrap(a, 32'd2);
      default: ans.value = 32'd0;
    endcase
    return ans;
  endfunction

  assign pending = answers_q.size();

  always @(posedge clk) begin
    alu_answer_t want;
    if (rst) begin
      errors <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_q.size() == 0) begin
          $error("unexpected result %h", result);
          errors <= errors + 1;
        end else begin
          want = answers_q.pop_front();
          if (result !== want.value) begin
            $error("result: expected %h actual %h", want.value, result);
            errors <= errors + 1;
          end else if (divide_by_zero !== want.dz) begin
            $error("divide_by_zero: expected %b actual %b", want.dz, divide_by_zero);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready) begin
        answers_q.push_back(compute_answer(opcode, operand_a, operand_b));
      end
    end
  end

endmodule

// ===== test/tb_integer_alu_with_div_pow.sv =====
// testbench top: request stimulus, result back-pressure and verdict
module tb_integer_alu_with_div_pow;
  import ialu_pkg::*;

  localparam int NumRandom = 1130;
  localparam int IdleLimit = 20000;

  logic                        clk;
  logic                        rst;
  logic                        in_valid;
  logic                        in_ready;
  logic [2:0]                  opcode;
  logic signed [DataWidth-1:0] operand_a;
  logic signed [DataWidth-1:0] operand_b;
  logic                        out_valid;
  logic                        out_ready;
  logic signed [DataWidth-1:0] result;
  logic                        divide_by_zero;
  int                          errors;
  int                          pending;
  int                          idle_cycles;
  logic                        hold_off;
  logic                        calm;

  integer_alu_with_div_pow i_dut (
    .clk, .rst, .in_valid, .in_ready, .opcode, .operand_a, .operand_b,
    .out_valid, .out_ready, .result, .divide_by_zero
  );

  tb_integer_alu_with_div_pow_checker i_checker (
    .clk, .rst, .in_valid, .in_ready, .opcode, .operand_a, .operand_b,
    .out_valid, .out_ready, .result, .divide_by_zero, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'hffff_ffff;
      3: return 32'd0;
      4: return $urandom_range(0, 40) - 20;
      default: return $urandom();
    endcase
  endfunction

  // valid stays high after the accept; the caller drops it or sends the next request
  task automatic send_request(logic [2:0] op, logic [31:0] a, logic [31:0] b);
    in_valid  <= 1'b1;
    opcode    <= op;
    operand_a <= a;
    operand_b <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic random_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // result side: random stalls, one long hold-off
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ready <= 1'b1;
        wait (!hold_off);
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // watchdog on accepted requests and results
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] a;
    logic [31:0] b;
    logic [2:0]  op;
    rst = 1'b1;
    in_valid = 1'b0;
    opcode = '0;
    operand_a = '0;
    operand_b = '0;
    hold_off = 1'b0;
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request(OP_ADD, 32'h7fff_ffff, 32'd1);
    send_request(OP_ADD, 32'h8000_0000, 32'hffff_ffff);
    send_request(OP_SUB, 32'h8000_0000, 32'd1);
    send_request(OP_SUB, 32'd0, 32'h8000_0000);
    send_request(OP_MUL, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
    send_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
    send_request(OP_REM, 32'h8000_0000, 32'hffff_ffff);
    send_request(OP_DIV, 32'd5, 32'd0);
    send_request(OP_REM, 32'h8000_0000, 32'd0);
    send_request(OP_DIV, 32'hffff_fff9, 32'd2);
    send_request(OP_REM, 32'hffff_fff9, 32'd2);
    send_request(OP_REM, 32'd7, 32'hffff_fffe);
    send_request(OP_POW, 32'd3, 32'd0);
    send_request(OP_POW, 32'd3, 32'hffff_ffff);
    send_request(OP_POW, 32'd3, 32'h7fff_ffff);
    send_request(OP_POW, 32'hffff_ffff, 32'd31);
    send_request(OP_POW, 32'd2, 32'd31);
    send_request(OP_SQR, 32'h8000_0000, 32'h1234_5678);
    send_request(OP_SQR, 32'hffff_ffff, 32'hffff_ffff);
    send_request(OP_NOP, 32'hffff_ffff, 32'hffff_ffff);
    in_valid <= 1'b0;

    // pause until the pipeline has drained
    @(posedge clk);
    wait (pending == 0);
    @(posedge clk);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == 300) hold_off <= 1'b1;
      if (i == 320) hold_off <= 1'b0;
      if (i == NumRandom - 100) calm <= 1'b1;
      op = 3'($urandom_range(0, 7));
      a = pick_operand();
      b = pick_operand();
      if (opcode_t'(op) == OP_POW && $urandom_range(0, 3) != 0) begin
        b = $urandom_range(0, 40);
      end
      send_request(op, a, b);
      random_gap();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (120) @(posedge clk);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ialu_pkg.sv
src/ialu_datapath.sv
src/ialu_ctrl.sv
src/integer_alu_with_div_pow.sv
test/tb_integer_alu_with_div_pow_checker.sv
test/tb_integer_alu_with_div_pow.sv
